>>> hdl/fcsc_pkg.sv
// ----------------------------------------------------------------------------
// fcsc_pkg: shared constants for the front-coding string compressor
// Line store sizing, position and length widths, varint grouping, op codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsc_pkg;

  // Longest string kept in the line store
  localparam int MAX_LEN = 4096;

  // Position in the current string, saturating
  localparam int          POS_W   = 17;
  localparam logic [16:0] POS_MAX = 17'h1FFFF;

  // Stored length and shared prefix count hold 0..MAX_LEN
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  // Line store address
  localparam int ADDR_W = $clog2(MAX_LEN);

  // Varint: 7-bit groups needed for a LEN_W-bit count
  localparam int VAR_N = (LEN_W + 6) / 7;
  // Byte index within one item's burst (varint bytes plus the character)
  localparam int IDX_W = $clog2(VAR_N + 1);

  localparam logic [POS_W-1:0] MAX_LEN_POS = POS_W'(MAX_LEN);
  localparam logic [LEN_W-1:0] MAX_LEN_LEN = LEN_W'(MAX_LEN);

  // Input op codes
  localparam logic OP_CHAR  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

endpackage

`default_nettype wire

>>> hdl/fcsc_ram.sv
// ----------------------------------------------------------------------------
// fcsc_ram: generic simple dual-port RAM
// One write port, one read port with enable and registered read data.
// A read and a write at the same address return the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/front_coding_string_compressor_core.sv
// ----------------------------------------------------------------------------
// front_coding_string_compressor_core: front-coding (prefix) string compressor
// Compares each null-terminated string with the previous one and emits the
// shared prefix length as a varint, then the differing suffix and terminator.
// ----------------------------------------------------------------------------
// Usage: one character byte (or a clear op) enters per item on the in_
// channel; a new item is taken every cycle unless the compare stage is still
// sending or the output is stalled. Bytes that still match the stored string
// produce no output; a byte that passes through sends one byte; the byte that
// ends the match sends the varint bytes, then itself, as the single output
// register sends one byte per cycle while out_ready allows. Each item does one
// read and at most one write of the line store, a RAM with registered read
// data; no clearing pass follows reset, since only entries below the stored
// length are compared. Strings longer than MAX_LEN pass through whole but are
// stored truncated; their bytes from position MAX_LEN on carry out_truncated.
`default_nettype none

module front_coding_string_compressor_core
  import fcsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input items
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_op,
  input  wire logic [7:0] in_byte,
  // result items
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_byte,
  output logic            out_is_prefix_byte,
  output logic            out_end_of_record,
  output logic            out_truncated
);

  // Front state, updated at accept
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [LEN_W-1:0]  prev_len_r, prev_len_nxt;
  logic              ovf_r, ovf_nxt;

  // Match state, updated when the item in the compare stage retires
  logic              sm_r, sm_nxt;
  logic [LEN_W-1:0]  mc_r, mc_nxt;

  // Compare stage
  logic              s1_v_r, s1_v_nxt;
  logic              s1_clr_r;
  logic [7:0]        s1_c_r;
  logic              s1_lt_r;
  logic              s1_ovf_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // Output register
  logic              out_v_r, out_v_nxt;
  logic [7:0]        out_byte_r;
  logic              out_pfx_r, out_eor_r, out_trunc_r;

  logic              accept;
  logic              ovf_item;
  logic              ram_we;
  logic [7:0]        rdata;

  logic              same, emit_pfx, emit_any, last, push, s1_done;
  logic [IDX_W-1:0]  vlen;
  logic [7:0]        vbyte;
  logic [7:0]        emit_byte;
  logic              emit_is_pfx, emit_eor;

  assign accept = in_valid && in_ready;

  // Overflow flag as seen by this item's results
  assign ovf_item = ovf_r || ((in_byte != 8'd0) && (pos_r >= MAX_LEN_POS));

  assign ram_we = accept && (in_op == OP_CHAR) && (in_byte != 8'd0) &&
                  (pos_r < MAX_LEN_POS);

  // Line store: read the entry at the current position, write the new byte
  fcsc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r[ADDR_W-1:0]),
    .wdata (in_byte),
    .re    (accept),
    .raddr (pos_r[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // Front state next values
  always_comb begin
    pos_nxt      = pos_r;
    prev_len_nxt = prev_len_r;
    ovf_nxt      = ovf_r;
    if (accept) begin
      if (in_op == OP_CLEAR) begin
        pos_nxt      = '0;
        prev_len_nxt = '0;
        ovf_nxt      = 1'b0;
      end else if (in_byte == 8'd0) begin
        pos_nxt      = '0;
        ovf_nxt      = 1'b0;
        prev_len_nxt = (pos_r < MAX_LEN_POS) ? pos_r[LEN_W-1:0] : MAX_LEN_LEN;
      end else begin
        ovf_nxt = ovf_item;
        if (pos_r < POS_MAX) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  // Varint of the shared prefix count: length and the byte at idx_r
  always_comb begin
    vlen  = IDX_W'(1);
    vbyte = 8'd0;
    for (int g = 1; g < VAR_N; g++) begin
      if ((mc_r >> (7 * g)) != '0) begin
        vlen = IDX_W'(g + 1);
      end
    end
    for (int g = 0; g < VAR_N; g++) begin
      if (idx_r == IDX_W'(g)) begin
        vbyte[6:0] = 7'(mc_r >> (7 * g));
        vbyte[7]   = ((mc_r >> (7 * (g + 1))) != '0);
      end
    end
  end

  // Compare and emit decision
  assign same     = (s1_c_r != 8'd0) && s1_lt_r && (rdata == s1_c_r);
  assign emit_pfx = !s1_clr_r && sm_r && !same;
  assign emit_any = !s1_clr_r && (!sm_r || !same);
  assign last     = !emit_pfx || (idx_r == vlen);

  always_comb begin
    if (emit_pfx && (idx_r < vlen)) begin
      emit_byte   = vbyte;
      emit_is_pfx = 1'b1;
      emit_eor    = 1'b0;
    end else begin
      emit_byte   = s1_c_r;
      emit_is_pfx = 1'b0;
      emit_eor    = (s1_c_r == 8'd0);
    end
  end

  assign push     = s1_v_r && emit_any && (!out_v_r || out_ready);
  assign s1_done  = s1_v_r && (!emit_any || (push && last));
  assign in_ready = !s1_v_r || s1_done;

  // Compare stage control and match state next values
  always_comb begin
    s1_v_nxt = s1_v_r;
    idx_nxt  = idx_r;
    sm_nxt   = sm_r;
    mc_nxt   = mc_r;
    if (s1_done) begin
      s1_v_nxt = 1'b0;
      idx_nxt  = '0;
      if (s1_clr_r || (s1_c_r == 8'd0)) begin
        sm_nxt = 1'b1;
        mc_nxt = '0;
      end else if (sm_r) begin
        if (same) begin
          mc_nxt = mc_r + LEN_W'(1);
        end else begin
          sm_nxt = 1'b0;
        end
      end
    end else if (push) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (accept) begin
      s1_v_nxt = 1'b1;
    end
  end

  // Output register valid
  always_comb begin
    out_v_nxt = out_v_r;
    if (push) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      prev_len_r <= '0;
      ovf_r      <= 1'b0;
      sm_r       <= 1'b1;
      mc_r       <= '0;
      s1_v_r     <= 1'b0;
      idx_r      <= '0;
      out_v_r    <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      prev_len_r <= prev_len_nxt;
      ovf_r      <= ovf_nxt;
      sm_r       <= sm_nxt;
      mc_r       <= mc_nxt;
      s1_v_r     <= s1_v_nxt;
      idx_r      <= idx_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  // Compare stage payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_clr_r <= (in_op == OP_CLEAR);
      s1_c_r   <= in_byte;
      s1_lt_r  <= (pos_r < POS_W'(prev_len_r));
      s1_ovf_r <= ovf_item;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (push) begin
      out_byte_r  <= emit_byte;
      out_pfx_r   <= emit_is_pfx;
      out_eor_r   <= emit_eor;
      out_trunc_r <= s1_ovf_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_byte           = out_byte_r;
  assign out_is_prefix_byte = out_pfx_r;
  assign out_end_of_record  = out_eor_r;
  assign out_truncated      = out_trunc_r;

endmodule

`default_nettype wire

>>> tb/front_code_checker.sv
// ----------------------------------------------------------------------------
// front_code_checker: result checker for the front-coding string compressor
// Watches both channels, predicts the compressed byte stream from the
// accepted items and compares each accepted result with the oldest
// prediction. Counts are handed back to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module front_code_checker
  import fcsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_is_prefix_byte,
  input  logic       out_end_of_record,
  input  logic       out_truncated,
  output int         errors,
  output int         pending,
  output int         items_seen,
  output int         results_seen,
  output int         prefix_seen,
  output int         trunc_seen
);

  localparam logic [7:0] TERM_BYTE  = 8'h00;

  // one predicted byte of the compressed stream
  typedef struct packed {
    logic [7:0] data;
    logic       pfx;
    logic       eor;
    logic       trunc;
  } code_byte_t;

  code_byte_t expected_bytes [$];

  // predictor state
  logic [7:0]       line_store [MAX_LEN];
  logic [LEN_W-1:0] stored_len;
  logic [POS_W-1:0] cur_pos;
  logic             matching;
  logic [LEN_W-1:0] shared_len;
  logic             long_str;

  int mismatch_count = 0;
  int item_count     = 0;
  int result_count   = 0;
  int prefix_count   = 0;
  int trunc_count    = 0;

  task automatic start_word();
    cur_pos    = '0;
    matching   = 1'b1;
    shared_len = '0;
    long_str   = 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic pfx, input logic eor);
    code_byte_t e;
    e.data  = b;
    e.pfx   = pfx;
    e.eor   = eor;
    e.trunc = long_str;
    expected_bytes.push_back(e);
  endtask

  // Predict the compressed bytes caused by one accepted item
  task automatic front_code_item(input logic op, input logic [7:0] c);
    logic [LEN_W-1:0] v;
    logic [7:0]       grp;
    logic             hit;
    if (op == OP_CLEAR) begin
      // history dropped, partial record abandoned
      stored_len = '0;
      start_word();
    end else begin
      if (c != TERM_BYTE && cur_pos >= MAX_LEN_POS) long_str = 1'b1;
      if (matching) begin
        hit = (c != TERM_BYTE) && (cur_pos < POS_W'(stored_len)) &&
              (line_store[cur_pos[ADDR_W-1:0]] == c);
        if (hit) begin
          shared_len = shared_len + LEN_W'(1);
        end else begin
          // prefix length as varint, low group first
          v = shared_len;
          do begin
            grp = {1'b0, v[6:0]};
            v   = v >> 7;
            if (v != '0) grp[7] = 1'b1;
            push_byte(grp, 1'b1, 1'b0);
          end while (v != '0);
          matching = 1'b0;
          push_byte(c, 1'b0, c == TERM_BYTE);
        end
      end else begin
        push_byte(c, 1'b0, c == TERM_BYTE);
      end
      if (c == TERM_BYTE) begin
        stored_len = (cur_pos < MAX_LEN_POS) ? LEN_W'(cur_pos) : MAX_LEN_LEN;
        start_word();
      end else begin
        if (cur_pos < MAX_LEN_POS) line_store[cur_pos[ADDR_W-1:0]] = c;
        if (cur_pos != POS_MAX) cur_pos = cur_pos + POS_W'(1);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Compare results first (they come from earlier items), then predict
  always @(posedge clk) begin : watch
    code_byte_t e;
    if (!rst_n) begin
      stored_len = '0;
      start_word();
      expected_bytes.delete();
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (out_is_prefix_byte) prefix_count++;
        if (out_truncated) trunc_count++;
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none actual %0h", $time, out_byte);
        end else begin
          e = expected_bytes.pop_front();
          check_field("out_byte", e.data, out_byte);
          check_field("out_is_prefix_byte", {7'd0, e.pfx}, {7'd0, out_is_prefix_byte});
          check_field("out_end_of_record", {7'd0, e.eor}, {7'd0, out_end_of_record});
          check_field("out_truncated", {7'd0, e.trunc}, {7'd0, out_truncated});
        end
      end
      if (in_valid && in_ready) begin
        item_count++;
        front_code_item(in_op, in_byte);
      end
    end
    errors       <= mismatch_count;
    pending      <= expected_bytes.size();
    items_seen   <= item_count;
    results_seen <= result_count;
    prefix_seen  <= prefix_count;
    trunc_seen   <= trunc_count;
  end

endmodule

>>> tb/tb_front_coding_string_compressor_core.sv
// ----------------------------------------------------------------------------
// tb_front_coding_string_compressor_core: testbench for the string compressor
// Drives strings, clears and abandoned strings with random gaps and output
// stalls, including a long receiver hold-off, and lets the checker score
// the compressed stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_front_coding_string_compressor_core;
  import fcsc_pkg::*;

  localparam logic [7:0] TERM_BYTE      = 8'h00;
  localparam int         HOLD_CYCLES    = 120;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         DRAIN_CYCLES   = 16;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_op;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_is_prefix_byte;
  logic       out_end_of_record;
  logic       out_truncated;

  int errors, pending, items_seen, results_seen, prefix_seen, trunc_seen;

  // idling controls, read by the sender task and the receiver process
  logic src_idle  = 1'b0;
  logic sink_idle = 1'b0;
  logic hold_req  = 1'b0;

  int         items_sent = 0;
  logic [7:0] last_word [$];

  front_coding_string_compressor_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_is_prefix_byte (out_is_prefix_byte),
    .out_end_of_record  (out_end_of_record),
    .out_truncated      (out_truncated)
  );

  front_code_checker i_front_code_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_is_prefix_byte (out_is_prefix_byte),
    .out_end_of_record  (out_end_of_record),
    .out_truncated      (out_truncated),
    .errors             (errors),
    .pending            (pending),
    .items_seen         (items_seen),
    .results_seen       (results_seen),
    .prefix_seen        (prefix_seen),
    .trunc_seen         (trunc_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one item, with an optional idle burst first; returns at acceptance
  task automatic send_item(input logic op, input logic [7:0] b);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Nonzero character, mostly from a small alphabet so prefixes repeat
  function automatic logic [7:0] rand_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(1, 255));
    return 8'($urandom_range(97, 100));
  endfunction

  // Mostly strings that share a random prefix with the last one, plus
  // stray clears and strings abandoned by a clear
  task automatic random_words(input int n);
    int         stop_at;
    int         keep;
    logic [7:0] word [$];
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 19))
        0: begin
          send_item(OP_CLEAR, 8'($urandom));
          last_word.delete();
        end
        1: begin
          repeat ($urandom_range(1, 4)) send_item(OP_CHAR, rand_char());
          send_item(OP_CLEAR, 8'($urandom));
          last_word.delete();
        end
        default: begin
          word.delete();
          keep = $urandom_range(0, last_word.size());
          for (int k = 0; k < keep; k++) word.push_back(last_word[k]);
          repeat ($urandom_range(0, 6)) word.push_back(rand_char());
          foreach (word[k]) send_item(OP_CHAR, word[k]);
          send_item(OP_CHAR, TERM_BYTE);
          last_word = word;
        end
      endcase
    end
  endtask

  // Receiver: random stalls, or one long hold-off on request
  initial begin : receiver
    logic held;
    held = 1'b0;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: cycles with no item accepted on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d quiet cycles, %0d results outstanding",
                 quiet, pending);
        $display("tb_front_coding_string_compressor_core: FAIL");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_op    <= OP_CHAR;
    in_byte  <= TERM_BYTE;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty string, byte extremes, full match, clears
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_item(OP_CHAR, TERM_BYTE);
    send_item(OP_CHAR, 8'hFF);
    send_item(OP_CHAR, 8'h01);
    send_item(OP_CHAR, TERM_BYTE);
    // same string again: matches right up to the terminator
    send_item(OP_CHAR, 8'hFF);
    send_item(OP_CHAR, 8'h01);
    send_item(OP_CHAR, TERM_BYTE);
    send_item(OP_CHAR, 8'hFF);
    send_item(OP_CHAR, 8'h80);
    send_item(OP_CHAR, 8'h7F);
    send_item(OP_CHAR, TERM_BYTE);
    // clear ignores its byte
    send_item(OP_CLEAR, 8'hFF);
    send_item(OP_CHAR, 8'hFF);
    send_item(OP_CHAR, TERM_BYTE);
    // string abandoned mid-way by a clear
    send_item(OP_CHAR, 8'hFF);
    send_item(OP_CHAR, 8'h02);
    send_item(OP_CLEAR, TERM_BYTE);
    send_item(OP_CHAR, 8'h41);
    send_item(OP_CHAR, TERM_BYTE);

    // random strings with idling on both sides
    random_words(40);

    // receiver holds off while the sender keeps pushing pass-through bytes
    hold_req = 1'b1;
    send_item(OP_CLEAR, TERM_BYTE);
    repeat (30) send_item(OP_CHAR, 8'($urandom_range(1, 255)));
    send_item(OP_CHAR, TERM_BYTE);
    last_word.delete();

    // more random strings with idling
    random_words(25);

    // last part: random strings, no idling
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    random_words(50);
    in_valid <= 1'b0;

    // drain, then let any stray result show up
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items: prefix-sharing strings, clears, abandoned strings and a %0d-cycle",
             items_seen, HOLD_CYCLES);
    $display("receiver hold-off; %0d result bytes, %0d varint, %0d truncated, %0d errors.",
             results_seen, prefix_seen, trunc_seen, errors);
    if (errors == 0 && pending == 0) begin
      $display("tb_front_coding_string_compressor_core: PASS");
    end else begin
      $display("tb_front_coding_string_compressor_core: FAIL");
    end
    $finish;
  end

endmodule
